[rtl/core/u2u8_pkg.sv]
// Shared types, constants and byte-encoding helpers for the UTF-8 encoder.
package u2u8_pkg;

  // Sizing
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
  localparam int unsigned VALUE_W = 31;  // encodable values are below 2^31
  localparam int unsigned UNIT_W  = 16;

  // UTF-16 surrogate tags on bits 15..10
  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  // Offset added to a joined surrogate pair
  localparam logic [VALUE_W-1:0] HALF_BASE = 31'h0001_0000;

  // Length band limits
  localparam logic [VALUE_W-1:0] LIM_1 = 31'h0000_0080;
  localparam logic [VALUE_W-1:0] LIM_2 = 31'h0000_0800;
  localparam logic [VALUE_W-1:0] LIM_3 = 31'h0001_0000;
  localparam logic [VALUE_W-1:0] LIM_4 = 31'h0020_0000;
  localparam logic [VALUE_W-1:0] LIM_5 = 31'h0400_0000;

  // Byte count of a released high surrogate
  localparam logic [2:0] HELD_LEN = 3'd3;

  localparam logic [7:0] CONT_MARK = 8'h80;
  localparam logic [7:0] CONT_MASK = 8'h3f;

  // One queued job: an optional released high surrogate, then an optional main value
  typedef struct packed {
    logic               held_en;
    logic [UNIT_W-1:0]  held;
    logic               main_en;
    logic [VALUE_W-1:0] main_value;
    logic [2:0]         main_len;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [VALUE_W-1:0] v);
    logic [2:0] len;
    if (v < LIM_1) begin
      len = 3'd1;
    end else if (v < LIM_2) begin
      len = 3'd2;
    end else if (v < LIM_3) begin
      len = 3'd3;
    end else if (v < LIM_4) begin
      len = 3'd4;
    end else if (v < LIM_5) begin
      len = 3'd5;
    end else begin
      len = 3'd6;
    end
    return len;
  endfunction

  function automatic logic [7:0] lead_mark(input logic [2:0] len);
    logic [7:0] m;
    case (len)
      3'd2:    m = 8'hc0;
      3'd3:    m = 8'he0;
      3'd4:    m = 8'hf0;
      3'd5:    m = 8'hf8;
      3'd6:    m = 8'hfc;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Byte at position pos (0 = lead) of a len-byte sequence for v
  function automatic logic [7:0] utf8_byte(input logic [VALUE_W-1:0] v,
                                           input logic [2:0] len,
                                           input logic [2:0] pos);
    logic [2:0]         k;
    logic [VALUE_W-1:0] sh;
    logic [7:0]         b;
    k = len - 3'd1 - pos;
    case (k)
      3'd0:    sh = v;
      3'd1:    sh = v >> 6;
      3'd2:    sh = v >> 12;
      3'd3:    sh = v >> 18;
      3'd4:    sh = v >> 24;
      default: sh = v >> 30;
    endcase
    if (pos == 3'd0) begin
      b = lead_mark(len) | sh[7:0];
    end else begin
      b = CONT_MARK | (sh[7:0] & CONT_MASK);
    end
    return b;
  endfunction

endpackage

[rtl/core/u2u8_front.sv]
// Front end: takes code values, pairs surrogates and queues encode jobs.
module u2u8_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                source_format,
  input  logic                in_valid,
  input  logic [31:0]         code_value,
  input  logic                end_of_string,
  input  logic                q_full,
  output logic                push,
  output u2u8_pkg::job_t      job
);

  logic                            fmt;
  logic                            held_valid;
  logic                            held_valid_next;
  logic [u2u8_pkg::UNIT_W-1:0]     held;
  logic [u2u8_pkg::UNIT_W-1:0]     unit;
  logic                            is_high;
  logic                            is_low;
  logic                            accept;
  logic [u2u8_pkg::VALUE_W-1:0]    pair_value;

  assign accept     = in_valid && !q_full;
  assign unit       = code_value[15:0];
  assign is_high    = (unit[15:10] == u2u8_pkg::SURR_HIGH_TAG);
  assign is_low     = (unit[15:10] == u2u8_pkg::SURR_LOW_TAG);
  assign pair_value = u2u8_pkg::VALUE_W'({held[9:0], unit[9:0]}) + u2u8_pkg::HALF_BASE;

  always_comb begin
    job             = '0;
    held_valid_next = held_valid;
    if (!fmt) begin
      // UTF-32: zero and values with bit 31 set give nothing
      job.main_en    = (code_value != 32'd0) && !code_value[31];
      job.main_value = code_value[30:0];
    end else if (held_valid && is_low) begin
      job.main_en     = 1'b1;
      job.main_value  = pair_value;
      held_valid_next = 1'b0;
    end else begin
      job.held_en     = held_valid;
      job.held        = held;
      held_valid_next = is_high && !end_of_string;
      job.main_en     = !held_valid_next && (unit != 16'd0);
      job.main_value  = u2u8_pkg::VALUE_W'(unit);
    end
    job.main_len = u2u8_pkg::utf8_len(job.main_value);
  end

  assign push = accept && (job.held_en || job.main_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt        <= 1'b0;
      held_valid <= 1'b0;
    end else if (cfg_valid) begin
      fmt        <= source_format;
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fmt && is_high && !end_of_string) begin
      held <= unit;
    end
  end

  a_held_only_utf16: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> fmt) else $error("surrogate held outside UTF-16 mode");

  a_held_is_high: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (held[15:10] == u2u8_pkg::SURR_HIGH_TAG))
    else $error("held unit is not a high surrogate");

endmodule

[rtl/core/u2u8_queue.sv]
// Short job queue between the front and back ends.
module u2u8_queue #(
  parameter int unsigned DEPTH = u2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u2u8_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output u2u8_pkg::job_t q_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  u2u8_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_job   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("job pushed into a full queue");

endmodule

[rtl/core/u2u8_back.sv]
// Back end: expands queued jobs into UTF-8 bytes through an output register.
module u2u8_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  u2u8_pkg::job_t q_job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           last_byte
);

  u2u8_pkg::job_t cur;
  logic           cur_valid;
  logic [3:0]     cnt;
  logic [3:0]     offset;
  logic [3:0]     total;
  logic [2:0]     main_pos;
  logic           out_free;
  logic           emit;
  logic           at_last;
  logic [7:0]     byte_next;

  assign offset   = cur.held_en ? 4'(u2u8_pkg::HELD_LEN) : 4'd0;
  assign total    = offset + (cur.main_en ? 4'(cur.main_len) : 4'd0);
  assign main_pos = 3'(cnt - offset);
  assign out_free = !out_valid || !out_stall;
  assign emit     = cur_valid && out_free;
  assign at_last  = (cnt == total - 4'd1);
  assign pop      = q_valid && (!cur_valid || (emit && at_last));

  always_comb begin
    if (cur.held_en && (cnt < offset)) begin
      byte_next = u2u8_pkg::utf8_byte(u2u8_pkg::VALUE_W'(cur.held),
                                      u2u8_pkg::HELD_LEN, cnt[2:0]);
    end else begin
      byte_next = u2u8_pkg::utf8_byte(cur.main_value, cur.main_len, main_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        cnt       <= '0;
      end else if (emit) begin
        cur_valid <= !at_last;
        cnt       <= cnt + 4'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
    if (emit) begin
      out_byte  <= byte_next;
      last_byte <= at_last;
    end
  end

  a_job_has_bytes: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.held_en || cur.main_en)) else $error("empty job loaded");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cnt < total)) else $error("byte counter ran past job");

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && cur.main_en) |-> (cur.main_len != 3'd0 && cur.main_len <= 3'd6))
    else $error("illegal sequence length");

endmodule

[rtl/core/utf16_utf32_to_utf8_encoder.sv]
// Top level of the UTF-16 / UTF-32 to UTF-8 encoder.
//
//  channel  direction  handshake             payload
//  cfg      in         cfg_valid/cfg_ready   source_format
//  in       in         in_valid/in_stall     code_value, end_of_string
//  out      out        out_valid/out_stall   out_byte, last_byte
//
// One byte leaves per cycle while out_stall is low and jobs are queued; a request
// produces 1 to 6 bytes (typically up to 4), and a request giving no bytes is taken
// at the input without a queued job. The back-end byte counter steps through each job.
// An accepted request's job passes the queue and the back-end job register to out_byte.
// rst is synchronous; it clears the format (UTF-32), the held surrogate and queue.
// in_stall rises only while the job queue is full; out_stall holds the output register.
module utf16_utf32_to_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: any write also drops a held high surrogate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        source_format,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] code_value,
  input  logic        end_of_string,
  // output bytes
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  u2u8_pkg::job_t push_job;
  u2u8_pkg::job_t q_job;

  // configuration must only arrive while idle (the user's duty, not enforced here); it is always taken
  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // front: surrogate pairing and job classification
  u2u8_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .source_format (source_format),
    .in_valid      (in_valid),
    .code_value    (code_value),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  // decoupling queue
  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // back: one UTF-8 byte per cycle into the output register unless out_stall holds it
  u2u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

[tb/sv/utf8_byte_checker.sv]
// Checker for the UTF-8 encoder: predicts the bytes of each request and compares them.
`timescale 1ns / 1ps

module utf8_byte_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        source_format,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] code_value,
  input  logic        end_of_string,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  output int unsigned errors,
  output int unsigned bytes_due
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  utf8_byte_t  due_q[$];    // bytes still owed by the block, oldest first
  logic [7:0]  request_q[$]; // bytes of the request being predicted
  utf8_byte_t  due;
  logic        utf16_mode;
  logic [15:0] held_unit;
  logic        held_ok;

  function automatic logic [7:0] lead_bits(input int len);
    logic [7:0] m;
    case (len)
      2:       m = 8'hc0;
      3:       m = 8'he0;
      4:       m = 8'hf0;
      5:       m = 8'hf8;
      6:       m = 8'hfc;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // Original UTF-8 form, 1 to 6 bytes; zero and values with bit 31 set give nothing
  task automatic push_code_point(input logic [31:0] v);
    int          len;
    int          i;
    logic [31:0] part;
    if (v == 32'h0 || v[31]) return;
    if (v < 32'h0000_0080) len = 1;
    else if (v < 32'h0000_0800) len = 2;
    else if (v < 32'h0001_0000) len = 3;
    else if (v < 32'h0020_0000) len = 4;
    else if (v < 32'h0400_0000) len = 5;
    else len = 6;
    for (i = 0; i < len; i++) begin
      part = v >> (6 * (len - 1 - i));
      if (i == 0) request_q.push_back(lead_bits(len) | part[7:0]);
      else request_q.push_back(8'h80 | {2'b00, part[5:0]});
    end
  endtask

  task automatic encode_request(input logic [31:0] cv, input logic eos);
    logic [15:0] u;
    logic [31:0] joined;
    int          i;
    u = cv[15:0];
    request_q.delete();
    if (!utf16_mode) begin
      push_code_point(cv);
    end else if (held_ok && u[15:10] == u2u8_pkg::SURR_LOW_TAG) begin
      joined = (({16'h0, held_unit} - 32'h0000_d800) << 10)
             + ({16'h0, u} - 32'h0000_dc00) + 32'h0001_0000;
      held_ok   = 1'b0;
      held_unit = 16'h0;
      push_code_point(joined);
    end else begin
      if (held_ok) begin
        push_code_point({16'h0, held_unit});
        held_ok   = 1'b0;
        held_unit = 16'h0;
      end
      if (u[15:10] == u2u8_pkg::SURR_HIGH_TAG && !eos) begin
        held_unit = u;
        held_ok   = 1'b1;
      end else begin
        push_code_point({16'h0, u});
      end
    end
    for (i = 0; i < request_q.size(); i++) begin
      due_q.push_back('{value: request_q[i], last: (i == request_q.size() - 1)});
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      utf16_mode = 1'b0;
      held_ok    = 1'b0;
      held_unit  = 16'h0;
      bytes_due  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, out_byte, last_byte);
          errors++;
        end else begin
          due = due_q.pop_front();
          if (out_byte !== due.value) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, due.value, out_byte);
            errors++;
          end
          if (last_byte !== due.last) begin
            $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                     $time, due.last, last_byte);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        utf16_mode = source_format;
        held_ok    = 1'b0;
        held_unit  = 16'h0;
      end
      if (in_valid && !in_stall) encode_request(code_value, end_of_string);
      bytes_due = due_q.size();
    end
  end

endmodule

[tb/sv/tb_utf16_utf32_to_utf8_encoder.sv]
// Testbench top for the UTF-16 / UTF-32 to UTF-8 encoder: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_utf16_utf32_to_utf8_encoder;

  // Sized for a worst run of roughly 400 requests x 6 bytes under the longest stalls,
  // plus gaps and drain pauses; this is several times that.
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PHASE_ITEMS   = 70;
  localparam int unsigned SETTLE_CYCLES = 8;   // settle time after draining, with margin

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        source_format;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] code_value;
  logic        end_of_string;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last_byte;

  int unsigned errors;
  int unsigned bytes_due;
  int unsigned items_sent;
  int unsigned cycle_count;
  int unsigned stall_left;
  logic        gaps_on;
  logic        stalls_on;

  utf16_utf32_to_utf8_encoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .source_format (source_format),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_value    (code_value),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_byte     (last_byte)
  );

  utf8_byte_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .source_format (source_format),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .code_value    (code_value),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_byte     (last_byte),
    .errors        (errors),
    .bytes_due     (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("utf16_utf32_to_utf8_encoder regression: fail");
    $finish;
  end

  // Receiver back-pressure: random bursts of stalled cycles. Only one
  // assignment per falling edge, so a burst never glitches.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stalls_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Present one request at a falling edge and hold it until accepted. Valid is
  // left high afterwards so back-to-back requests keep it asserted; a gap
  // lowers it first.
  task automatic send_request(input logic [31:0] cv, input logic eos);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    code_value    <= cv;
    end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (bytes_due != 0) @(negedge clk);
  endtask

  // Format writes only go in once the block has gone quiet: every owed byte
  // out, and a few more cycles for requests that produce nothing.
  task automatic write_format(input logic fmt);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid     <= 1'b1;
    source_format <= fmt;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // UTF-32 values, weighted towards the short forms but reaching every length
  function automatic logic [31:0] rand_utf32();
    int          band;
    logic [31:0] v;
    band = $urandom_range(0, 15);
    if (band < 2) begin
      v = $urandom();
    end else if (band == 2) begin
      case ($urandom_range(0, 5))
        0:       v = 32'h0000_0000;
        1:       v = 32'h8000_0000;
        2:       v = 32'hffff_ffff;
        3:       v = 32'h7fff_ffff;
        4:       v = 32'h0000_0080;
        default: v = 32'h0000_0800;
      endcase
    end else if (band < 9) begin
      v = $urandom_range(32'h01, 32'h7f);
    end else if (band < 12) begin
      v = $urandom_range(32'h80, 32'h7ff);
    end else if (band < 14) begin
      v = $urandom_range(32'h800, 32'hffff);
    end else if (band == 14) begin
      v = $urandom_range(32'h1_0000, 32'h1f_ffff);
    end else if ($urandom_range(0, 1) == 0) begin
      v = $urandom_range(32'h20_0000, 32'h3ff_ffff);
    end else begin
      v = $urandom_range(32'h400_0000, 32'h7fff_ffff);
    end
    return v;
  endfunction

  // A UTF-16 unit with junk in the upper half now and then; the block ignores it
  function automatic logic [31:0] dress_unit(input logic [15:0] u);
    logic [31:0] r;
    r = $urandom();
    if ($urandom_range(0, 3) != 0) r[31:16] = 16'h0;
    return {r[31:16], u};
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hd800 | 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'hdc00 | 16'($urandom_range(0, 1023));
  endfunction

  // Basic-plane unit outside the surrogate range
  function automatic logic [15:0] rand_bmp();
    logic [15:0] r;
    r = 16'($urandom_range(0, 16'hf7ff));
    if (r >= 16'hd800) r = r + 16'h0800;
    return r;
  endfunction

  // Mostly well-formed text: pairs and plain units, with some broken
  // sequences and raw noise mixed in.
  task automatic send_utf16_run();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        send_request(dress_unit(rand_high()), 1'b0);
        send_request(dress_unit(rand_low()), $urandom_range(0, 5) == 0);
      end
      4, 5:    send_request(dress_unit(rand_bmp()), $urandom_range(0, 7) == 0);
      6:       send_request(dress_unit(rand_high()), 1'b1);  // flushed at string end
      7:       send_request(dress_unit(rand_low()), 1'($urandom_range(0, 1)));  // unpaired low
      8: begin
        // held high surrogate followed by something that is not a low one
        send_request(dress_unit(rand_high()), 1'b0);
        case ($urandom_range(0, 2))
          0:       send_request(dress_unit(rand_high()), 1'($urandom_range(0, 1)));
          1:       send_request(dress_unit(16'h0000), 1'($urandom_range(0, 1)));
          default: send_request(dress_unit(rand_bmp()), 1'($urandom_range(0, 1)));
        endcase
      end
      default: send_request($urandom(), 1'($urandom_range(0, 1)));
    endcase
  endtask

  initial begin
    int unsigned p;
    int unsigned target;
    logic        fmt;

    rst           = 1'b1;
    cfg_valid     = 1'b0;
    source_format = 1'b0;
    in_valid      = 1'b0;
    code_value    = 32'h0;
    end_of_string = 1'b0;
    items_sent    = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed, UTF-32 from reset: every length band at both edges, zero,
    // and the too-large values; a surrogate value is encoded as it stands.
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h0000_007f, 1'b1);
    send_request(32'h0000_0080, 1'b0);
    send_request(32'h0000_07ff, 1'b0);
    send_request(32'h0000_0800, 1'b0);
    send_request(32'h0000_ffff, 1'b0);
    send_request(32'h0001_0000, 1'b0);
    send_request(32'h001f_ffff, 1'b0);
    send_request(32'h0020_0000, 1'b0);
    send_request(32'h03ff_ffff, 1'b0);
    send_request(32'h0400_0000, 1'b0);
    send_request(32'h7fff_ffff, 1'b0);
    send_request(32'h8000_0000, 1'b0);
    send_request(32'hffff_ffff, 1'b1);
    send_request(32'h0000_d800, 1'b0);

    // Directed, UTF-16: lowest and highest pairs, an unpaired low, a high at
    // string end, high then high, high then nothing, and junk upper bits.
    write_format(1'b1);
    send_request(32'h0000_d800, 1'b0);
    send_request(32'h0000_dc00, 1'b0);
    send_request(32'h0000_dbff, 1'b0);
    send_request(32'h0000_dfff, 1'b1);
    send_request(32'h0000_dc00, 1'b0);
    send_request(32'h0000_dabc, 1'b1);
    send_request(32'h0000_d801, 1'b0);
    send_request(32'h0000_d802, 1'b1);
    send_request(32'h0000_d803, 1'b0);
    send_request(32'hffff_0000, 1'b0);
    send_request(32'hffff_0041, 1'b0);
    // leave a high surrogate held; the next format write must drop it
    send_request(32'h0000_d805, 1'b0);

    // Random phases alternating the format; the last one runs flat out
    for (p = 0; p < 5; p++) begin
      fmt = (p % 2 == 0);
      write_format(fmt);
      if (p == 4) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        // once: sender holds off until the output side has caught up
        if (p == 1 && items_sent + 40 == target) begin
          in_valid <= 1'b0;
          wait_drained();
          @(negedge clk);
        end
        if (fmt) send_utf16_run();
        else send_request(rand_utf32(), 1'($urandom_range(0, 1)));
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES + 4) @(negedge clk);
    if (bytes_due != 0) $display("%0t: %0d expected bytes never arrived", $time, bytes_due);
    if (errors == 0 && bytes_due == 0) begin
      $display("utf16_utf32_to_utf8_encoder regression: pass");
    end else begin
      $display("utf16_utf32_to_utf8_encoder regression: fail");
    end
    $finish;
  end

endmodule
